FILE: src/asm_lex_pkg.sv
// Package for the assembly line lexer: token kinds, error causes, lexer modes,
// the result word layout and the keyword matching helper.
// No dependencies.
package asm_lex_pkg;

  // lexer modes between characters
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_COMMENT   = 3'd1,
    MODE_CHAR_OPEN = 3'd2,
    MODE_CHAR_GOT  = 3'd3,
    MODE_STRING    = 3'd4,
    MODE_NUMBER    = 3'd5,
    MODE_WORD      = 3'd6
  } lex_mode_e;

  // token kinds
  typedef enum logic [3:0] {
    KIND_END          = 4'd0,
    KIND_COMMA        = 4'd1,
    KIND_DOT          = 4'd2,
    KIND_COLON        = 4'd3,
    KIND_COMMENT      = 4'd4,
    KIND_CHAR         = 4'd5,
    KIND_STRING       = 4'd6,
    KIND_NUMBER       = 4'd7,
    KIND_LABEL        = 4'd8,
    KIND_WORD         = 4'd9,
    KIND_SECTION      = 4'd10,
    KIND_SECTION_TYPE = 4'd11,
    KIND_ERROR        = 4'd12
  } token_kind_e;

  // error causes
  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_UNKNOWN   = 2'd1,
    CAUSE_CHAR_CUT  = 2'd2,
    CAUSE_NO_CLOSE  = 2'd3
  } error_cause_e;

  // one result word
  typedef struct packed {
    token_kind_e  kind;
    error_cause_e cause;
    logic [7:0]   start;
    logic [7:0]   length;
    logic         last;
  } token_t;

  // keyword candidate bits: section, data, text
  localparam int unsigned KwSection = 0;
  localparam int unsigned KwData    = 1;
  localparam int unsigned KwText    = 2;

  // character codes
  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChDquot = 8'h22;
  localparam logic [7:0] ChUscor = 8'h5f;

  localparam logic [7:0] LenSection = 8'd7;
  localparam logic [7:0] LenShort   = 8'd4;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F")) ||
           (c == "x") || (c == "X");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUscor) || (c == ChDot);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

  // keyword letter at a position, zero past the end
  function automatic logic [7:0] kw_letter(input logic [1:0] idx, input logic [7:0] pos);
    logic [7:0] r;
    r = 8'd0;
    case (idx)
      2'd0: begin
        case (pos)
          8'd0: r = "S";
          8'd1: r = "E";
          8'd2: r = "C";
          8'd3: r = "T";
          8'd4: r = "I";
          8'd5: r = "O";
          8'd6: r = "N";
          default: r = 8'd0;
        endcase
      end
      2'd1: begin
        case (pos)
          8'd0: r = "D";
          8'd1: r = "A";
          8'd2: r = "T";
          8'd3: r = "A";
          default: r = 8'd0;
        endcase
      end
      2'd2: begin
        case (pos)
          8'd0: r = "T";
          8'd1: r = "E";
          8'd2: r = "X";
          8'd3: r = "T";
          default: r = 8'd0;
        endcase
      end
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // drop candidates that do not match the character at this position
  function automatic logic [2:0] kw_update(input logic [2:0] cand, input logic [7:0] pos,
                                           input logic [7:0] c);
    logic [7:0] u;
    logic [2:0] r;
    u = c;
    r = cand;
    if ((c >= "a") && (c <= "z")) begin
      u = c - 8'd32;
    end
    for (int i = 0; i < 3; i++) begin
      if (kw_letter(2'(i), pos) != u || u == 8'd0) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

FILE: src/assembly_line_lexer.sv
// Assembly line lexer: streaming tokenizer, one source character per word.
// Uses asm_lex_pkg for token kinds, causes, modes and keyword matching.
//
// Input channel: ch_i with in_valid_i; a word is taken at a clock edge where
// in_valid_i is high and in_stall_o is low. Output channel: one token per
// word on token_kind_o, error_cause_o, token_start_o, token_length_o and
// last_of_run_o, qualified by out_valid_o and held while out_stall_i is high.
// A character gives zero, one or two tokens; last_of_run_o marks the final
// token a character caused. Spaces and tabs give no token of their own, and
// comment bodies give none. The lexer takes one character per cycle while
// in_stall_o is low; its state updates and it pushes its tokens into a
// four-entry result queue whose head drives the outputs and which drains
// one token per cycle while out_stall_i is low. in_stall_o rises when fewer
// than two queue entries are free, so a stalled receiver backs up into the
// input.
// Reset (rst_ni low) empties the queue and returns the lexer to idle at
// column zero with all keyword candidates live.
module assembly_line_lexer #(
  parameter int LINE_COLUMNS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 ch_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 token_kind_o,
  output logic [1:0]                 error_cause_o,
  output logic [7:0]                 token_start_o,
  output logic [7:0]                 token_length_o,
  output logic                       last_of_run_o
);
  import asm_lex_pkg::*;

  localparam logic [7:0] ColLimit = (LINE_COLUMNS - 1 < 255) ? 8'(LINE_COLUMNS - 1) : 8'd255;
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  lex_mode_e  mode_q, mode_d;
  logic [7:0] column_q, column_d;
  logic [7:0] begin_q, begin_d;
  logic [7:0] count_q, count_d;
  logic [2:0] cand_q, cand_d;

  logic       in_acc, out_acc, eol, again;
  logic       close_vld, new_vld;
  token_t     close_tok, new_tok;

  token_t              queue_q [QDepth];
  logic [QAw-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QAw:0]        fill_q;
  logic [QAw-1:0]      second_ptr;
  logic [1:0]          push_cnt;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign eol     = (ch_i == ChLf) || (ch_i == ChNul);

  // token closing, token opening and state update for one character
  always_comb begin
    mode_d    = mode_q;
    begin_d   = begin_q;
    count_d   = count_q;
    cand_d    = cand_q;
    again     = 1'b0;
    close_vld = 1'b0;
    close_tok = '{kind: KIND_END, cause: CAUSE_NONE, start: begin_q, length: count_q,
                  last: 1'b0};
    new_vld   = 1'b0;
    new_tok   = '{kind: KIND_END, cause: CAUSE_NONE, start: column_q, length: 8'd1,
                  last: 1'b1};

    case (mode_q)
      MODE_COMMENT: begin
        if (eol) begin
          close_vld      = 1'b1;
          close_tok.kind = KIND_COMMENT;
          again          = 1'b1;
        end else begin
          count_d = sat_inc(count_q);
        end
      end
      MODE_CHAR_OPEN: begin
        if (eol) begin
          close_vld       = 1'b1;
          close_tok.kind  = KIND_ERROR;
          close_tok.cause = CAUSE_CHAR_CUT;
          again           = 1'b1;
        end else begin
          count_d = sat_inc(count_q);
          mode_d  = MODE_CHAR_GOT;
        end
      end
      MODE_CHAR_GOT: begin
        close_vld = 1'b1;
        if (ch_i == ChQuote) begin
          count_d          = sat_inc(count_q);
          close_tok.kind   = KIND_CHAR;
          close_tok.length = sat_inc(count_q);
          mode_d           = MODE_IDLE;
        end else begin
          close_tok.kind  = KIND_ERROR;
          close_tok.cause = CAUSE_NO_CLOSE;
          again           = 1'b1;
        end
      end
      MODE_STRING: begin
        if (ch_i == ChDquot) begin
          close_vld        = 1'b1;
          count_d          = sat_inc(count_q);
          close_tok.kind   = KIND_STRING;
          close_tok.length = sat_inc(count_q);
          mode_d           = MODE_IDLE;
        end else if (eol) begin
          close_vld       = 1'b1;
          close_tok.kind  = KIND_ERROR;
          close_tok.cause = CAUSE_NO_CLOSE;
          again           = 1'b1;
        end else begin
          count_d = sat_inc(count_q);
        end
      end
      MODE_NUMBER: begin
        if (is_num_char(ch_i)) begin
          count_d = sat_inc(count_q);
        end else begin
          close_vld      = 1'b1;
          close_tok.kind = KIND_NUMBER;
          again          = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_word_char(ch_i)) begin
          cand_d  = kw_update(cand_q, count_q, ch_i);
          count_d = sat_inc(count_q);
        end else begin
          close_vld = 1'b1;
          again     = 1'b1;
          if (ch_i == ChColon) begin
            close_tok.kind = KIND_LABEL;
          end else if (cand_q[KwSection] && count_q == LenSection) begin
            close_tok.kind = KIND_SECTION;
          end else if ((cand_q[KwData] || cand_q[KwText]) && count_q == LenShort) begin
            close_tok.kind = KIND_SECTION_TYPE;
          end else begin
            close_tok.kind = KIND_WORD;
          end
        end
      end
      default: begin
        again = 1'b1;
      end
    endcase

    // the character starts the next token
    if (again) begin
      mode_d  = MODE_IDLE;
      begin_d = column_q;
      count_d = 8'd1;
      if (ch_i == ChSpace || ch_i == ChTab) begin
        new_vld = 1'b0;
      end else if (eol) begin
        new_vld        = 1'b1;
        new_tok.kind   = KIND_END;
        new_tok.length = 8'd0;
      end else if (ch_i == ChComma) begin
        new_vld      = 1'b1;
        new_tok.kind = KIND_COMMA;
      end else if (ch_i == ChDot) begin
        new_vld      = 1'b1;
        new_tok.kind = KIND_DOT;
      end else if (ch_i == ChColon) begin
        new_vld      = 1'b1;
        new_tok.kind = KIND_COLON;
      end else if (ch_i == ChSemi) begin
        mode_d = MODE_COMMENT;
      end else if (ch_i == ChQuote) begin
        mode_d = MODE_CHAR_OPEN;
      end else if (ch_i == ChDquot) begin
        mode_d = MODE_STRING;
      end else if (is_digit(ch_i)) begin
        mode_d = MODE_NUMBER;
      end else if (is_alpha(ch_i) || ch_i == ChUscor) begin
        mode_d = MODE_WORD;
        cand_d = kw_update(3'b111, 8'd0, ch_i);
      end else begin
        new_vld       = 1'b1;
        new_tok.kind  = KIND_ERROR;
        new_tok.cause = CAUSE_UNKNOWN;
      end
    end

    close_tok.last = !new_vld;

    // column advance, saturating at the line limit and back to zero at end of line
    if (eol) begin
      column_d = 8'd0;
    end else begin
      column_d = (column_q < ColLimit) ? column_q + 8'd1 : ColLimit;
    end
  end

  // lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      column_q <= 8'd0;
      begin_q  <= 8'd0;
      count_q  <= 8'd0;
      cand_q   <= 3'b111;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      column_q <= column_d;
      begin_q  <= begin_d;
      count_q  <= count_d;
      cand_q   <= cand_d;
    end
  end

  // result queue pointers and fill
  assign second_ptr = wr_ptr_q + QAw'(close_vld);
  assign push_cnt   = in_acc ? (2'(close_vld) + 2'(new_vld)) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QAw'(push_cnt);
      rd_ptr_q <= rd_ptr_q + QAw'(out_acc);
      fill_q   <= fill_q + (QAw+1)'(push_cnt) - (QAw+1)'(out_acc);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc && close_vld) begin
      queue_q[wr_ptr_q] <= close_tok;
    end
    if (in_acc && new_vld) begin
      queue_q[second_ptr] <= new_tok;
    end
  end

  // outputs
  assign in_stall_o     = fill_q > (QAw+1)'(QDepth - 2);
  assign out_valid_o    = fill_q != '0;
  assign token_kind_o   = queue_q[rd_ptr_q].kind;
  assign error_cause_o  = queue_q[rd_ptr_q].cause;
  assign token_start_o  = queue_q[rd_ptr_q].start;
  assign token_length_o = queue_q[rd_ptr_q].length;
  assign last_of_run_o  = queue_q[rd_ptr_q].last;

endmodule
